// ===== rtl/core/rts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types, codes and defaults of the radio telegram ring store.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int SLOT_COUNT_DEF     = 8;
    localparam int TELEGRAM_BYTES_DEF = 32;
    localparam int RSSI_WINDOW_DEF    = 8;

    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 8;
    localparam int CFG_A_W = 1;

    localparam logic [CFG_A_W-1:0] CFG_SYNC_HIGH = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_SYNC_LOW  = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PAYLOAD = 3'd0,
        FUNC_RSSI    = 3'd1,
        FUNC_COMMIT  = 3'd2,
        FUNC_READ    = 3'd3,
        FUNC_QUERY   = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_PAD,
        ST_STORE,
        ST_RESP,
        ST_RD_ADDR,
        ST_RD_LOAD,
        ST_RD_WAIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic sum_en;
        logic div_en;
        logic pad_en;
        logic store_en;
        logic rd_load;
        logic load_status;
        logic step_clr;
        logic step_inc;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic out_free;
        logic eff_drop;
        logic fill_zero;
        logic seen_zero;
        logic sum_done;
        logic div_done;
        logic step_last;
    } sts_t;

endpackage

// ===== rtl/core/rts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_ctrl
// Sequencer of the ring store: item intake, commit steps and slot readout.
// ----------------------------------------------------------------------------
module rts_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rts_pkg::FUNC_W-1:0]         func,
    input  rts_pkg::sts_t                      sts,
    output rts_pkg::cmd_t                      cmd
);
    import rts_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && !sts.out_busy;
    assign accept   = in_ready && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(func))
                        FUNC_COMMIT:
                        begin
                            if (sts.eff_drop)
                                state_next = ST_RESP;
                            else if (sts.seen_zero)
                                state_next = ST_PAD;
                            else
                                state_next = ST_SUM;
                        end
                        FUNC_READ:   state_next = sts.fill_zero ? ST_RESP : ST_RD_ADDR;
                        FUNC_QUERY:  state_next = ST_RESP;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SUM:     if (sts.sum_done) state_next = ST_DIV;
            ST_DIV:     if (sts.div_done) state_next = ST_PAD;
            ST_PAD:     if (sts.step_last) state_next = ST_STORE;
            ST_STORE:   state_next = ST_RESP;
            ST_RESP:    state_next = ST_IDLE;
            ST_RD_ADDR: state_next = ST_RD_LOAD;
            ST_RD_LOAD: state_next = ST_RD_WAIT;
            ST_RD_WAIT:
            begin
                if (sts.out_free)
                    state_next = sts.step_last ? ST_IDLE : ST_RD_ADDR;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.accept = accept;
        case (state_reg)
            ST_SUM:
            begin
                cmd.sum_en   = 1'b1;
                cmd.step_clr = sts.sum_done;
                cmd.step_inc = !sts.sum_done;
            end
            ST_DIV:
            begin
                cmd.div_en   = 1'b1;
                cmd.step_clr = sts.div_done;
                cmd.step_inc = !sts.div_done;
            end
            ST_PAD:
            begin
                cmd.pad_en   = 1'b1;
                cmd.step_inc = 1'b1;
            end
            ST_STORE:   cmd.store_en = 1'b1;
            ST_RESP:    cmd.load_status = 1'b1;
            ST_RD_LOAD: cmd.rd_load = 1'b1;
            ST_RD_WAIT: cmd.step_inc = sts.out_free && !sts.step_last;
            default:    cmd.accept = accept;
        endcase
    end

endmodule

// ===== rtl/core/rts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_datapath
// Slot storage, telegram assembly, rssi averaging and the output register.
// ----------------------------------------------------------------------------
module rts_datapath #(
    parameter int SLOT_COUNT     = rts_pkg::SLOT_COUNT_DEF,
    parameter int TELEGRAM_BYTES = rts_pkg::TELEGRAM_BYTES_DEF,
    parameter int RSSI_WINDOW    = rts_pkg::RSSI_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rts_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [rts_pkg::BYTE_W-1:0]    cfg_data,
    input  logic [rts_pkg::FUNC_W-1:0]    func,
    input  logic [rts_pkg::BYTE_W-1:0]    data_byte,
    input  logic [rts_pkg::BYTE_W-1:0]    rssi_sample,
    input  logic [rts_pkg::TIME_W-1:0]    rx_time,
    input  rts_pkg::cmd_t                 cmd,
    output rts_pkg::sts_t                 sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rts_pkg::BYTE_W-1:0]    slot_byte,
    output logic [rts_pkg::INDEX_W-1:0]   byte_index,
    output logic [rts_pkg::TIME_W-1:0]    stored_time,
    output logic [rts_pkg::BYTE_W-1:0]    rssi_average,
    output logic                          ring_empty,
    output logic [rts_pkg::COUNT_W-1:0]   stored_count,
    output logic                          last
);
    import rts_pkg::*;

    localparam int SIW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW   = $clog2(SLOT_COUNT * TELEGRAM_BYTES);
    localparam int PSW  = $clog2(TELEGRAM_BYTES - 1);
    localparam int PW   = (RSSI_WINDOW > 1) ? $clog2(RSSI_WINDOW) : 1;
    localparam int SEW  = $clog2(RSSI_WINDOW + 1);
    localparam int FW   = $clog2(SLOT_COUNT + 1);
    localparam int SUMW = $clog2(RSSI_WINDOW * 255 + 1);
    localparam int M1   = (TELEGRAM_BYTES > SUMW) ? TELEGRAM_BYTES : SUMW;
    localparam int MAXS = (M1 > RSSI_WINDOW) ? M1 : RSSI_WINDOW;
    localparam int STW  = $clog2(MAXS + 1);
    localparam int MW   = TIME_W + BYTE_W;

    logic [BYTE_W-1:0]  sync_hi_reg, sync_hi_next;
    logic [BYTE_W-1:0]  sync_lo_reg, sync_lo_next;
    logic [SIW-1:0]     wslot_reg, wslot_next;
    logic [SIW-1:0]     rslot_reg, rslot_next;
    logic [SIW-1:0]     cur_reg, cur_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [BYTE_W-1:0]  avg_reg, avg_next;
    logic               open_reg, open_next;
    logic               drop_reg, drop_next;
    logic [PSW-1:0]     pseen_reg, pseen_next;
    logic [SEW-1:0]     seen_reg, seen_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PSW-1:0]     len_reg, len_next;
    logic [TIME_W-1:0]  stamp_reg, stamp_next;
    logic [SUMW-1:0]    acc_reg, acc_next;
    logic [SEW-1:0]     rem_reg, rem_next;
    logic [STW-1:0]     step_reg, step_next;

    logic               ov_reg, ov_next;
    logic [BYTE_W-1:0]  ob_reg, ob_next;
    logic [INDEX_W-1:0] oi_reg, oi_next;
    logic [TIME_W-1:0]  ot_reg, ot_next;
    logic [BYTE_W-1:0]  oa_reg, oa_next;
    logic               oe_reg, oe_next;
    logic [COUNT_W-1:0] oc_reg, oc_next;
    logic               ol_reg, ol_next;

    logic               eff_drop;
    logic [PSW-1:0]     eff_pseen;
    logic [SEW-1:0]     eff_seen;
    logic [PW-1:0]      eff_pos;
    logic [AW-1:0]      wbase;
    logic               sb_we;
    logic [AW-1:0]      sb_waddr;
    logic [BYTE_W-1:0]  sb_wdata;
    logic [AW-1:0]      sb_raddr;
    logic [BYTE_W-1:0]  sb_q;
    logic               h_we;
    logic [BYTE_W-1:0]  h_q;
    logic               m_we;
    logic [MW-1:0]      m_wdata;
    logic [MW-1:0]      m_q;
    logic [SEW:0]       rem_sh;
    logic               qbit;
    logic               fill_zero;

    assign eff_drop  = open_reg ? drop_reg : (fill_reg >= FW'(SLOT_COUNT));
    assign eff_pseen = open_reg ? pseen_reg : '0;
    assign eff_seen  = open_reg ? seen_reg : '0;
    assign eff_pos   = open_reg ? pos_reg : '0;
    assign wbase     = AW'(wslot_reg * TELEGRAM_BYTES);
    assign sb_raddr  = AW'(cur_reg * TELEGRAM_BYTES) + AW'(step_reg);
    assign fill_zero = (fill_reg == '0);
    assign rem_sh    = {rem_reg, acc_reg[SUMW-1]};
    assign qbit      = (rem_sh >= {1'b0, seen_reg});

    assign sts.out_busy  = ov_reg;
    assign sts.out_free  = !ov_reg || out_ready;
    assign sts.eff_drop  = eff_drop;
    assign sts.fill_zero = fill_zero;
    assign sts.seen_zero = (eff_seen == '0);
    assign sts.sum_done  = (step_reg == STW'(seen_reg));
    assign sts.div_done  = (step_reg == STW'(SUMW - 1));
    assign sts.step_last = (step_reg == STW'(TELEGRAM_BYTES - 1));

    always_comb
    begin
        sync_hi_next = sync_hi_reg;
        sync_lo_next = sync_lo_reg;
        wslot_next   = wslot_reg;
        rslot_next   = rslot_reg;
        cur_next     = cur_reg;
        fill_next    = fill_reg;
        avg_next     = avg_reg;
        open_next    = open_reg;
        drop_next    = drop_reg;
        pseen_next   = pseen_reg;
        seen_next    = seen_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        stamp_next   = stamp_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        sb_we        = 1'b0;
        sb_waddr     = wbase + AW'(2) + AW'(eff_pseen);
        sb_wdata     = data_byte;
        h_we         = 1'b0;
        m_we         = 1'b0;
        m_wdata      = {stamp_reg, avg_reg};

        if (cfg_we)
        begin
            if (cfg_addr == CFG_SYNC_HIGH)
                sync_hi_next = cfg_data;
            else
                sync_lo_next = cfg_data;
        end

        if (cmd.step_clr)
            step_next = '0;
        else if (cmd.step_inc)
            step_next = step_reg + STW'(1);

        if (cmd.accept)
        begin
            step_next = '0;
            case (func_t'(func))
                FUNC_PAYLOAD:
                begin
                    open_next  = 1'b1;
                    drop_next  = eff_drop;
                    pseen_next = eff_pseen;
                    seen_next  = eff_seen;
                    pos_next   = eff_pos;
                    if (!eff_drop)
                    begin
                        sb_we = (int'(eff_pseen) + 3 < TELEGRAM_BYTES);
                        if (eff_pseen < PSW'(TELEGRAM_BYTES - 2))
                            pseen_next = eff_pseen + PSW'(1);
                    end
                end
                FUNC_RSSI:
                begin
                    open_next  = 1'b1;
                    drop_next  = eff_drop;
                    pseen_next = eff_pseen;
                    seen_next  = eff_seen;
                    pos_next   = eff_pos;
                    if (!eff_drop)
                    begin
                        h_we = 1'b1;
                        if (int'(eff_pos) + 1 >= RSSI_WINDOW)
                            pos_next = '0;
                        else
                            pos_next = eff_pos + PW'(1);
                        if (eff_seen < SEW'(RSSI_WINDOW))
                            seen_next = eff_seen + SEW'(1);
                    end
                end
                FUNC_COMMIT:
                begin
                    pseen_next = eff_pseen;
                    seen_next  = eff_seen;
                    stamp_next = rx_time;
                    acc_next   = '0;
                    rem_next   = '0;
                    if (eff_pseen < PSW'(TELEGRAM_BYTES - 2))
                        len_next = eff_pseen;
                    else
                        len_next = PSW'(TELEGRAM_BYTES - 4);
                    if (eff_drop)
                    begin
                        open_next  = 1'b0;
                        drop_next  = 1'b0;
                        pseen_next = '0;
                        seen_next  = '0;
                        pos_next   = '0;
                    end
                end
                FUNC_READ:
                begin
                    if (!fill_zero)
                    begin
                        cur_next  = rslot_reg;
                        fill_next = fill_reg - FW'(1);
                        if (int'(rslot_reg) + 1 >= SLOT_COUNT)
                            rslot_next = '0;
                        else
                            rslot_next = rslot_reg + SIW'(1);
                    end
                end
                default:
                begin
                    open_next = open_reg;
                end
            endcase
        end

        if (cmd.sum_en && (step_reg != '0))
            acc_next = acc_reg + SUMW'(h_q);

        if (cmd.div_en)
        begin
            rem_next = qbit ? SEW'(rem_sh - {1'b0, seen_reg}) : rem_sh[SEW-1:0];
            acc_next = {acc_reg[SUMW-2:0], qbit};
        end

        if (cmd.pad_en)
        begin
            sb_waddr = wbase + AW'(step_reg);
            if (step_reg == '0)
            begin
                sb_we    = 1'b1;
                sb_wdata = sync_hi_reg;
            end
            else if (step_reg == STW'(1))
            begin
                sb_we    = 1'b1;
                sb_wdata = sync_lo_reg;
            end
            else
            begin
                sb_we    = (int'(step_reg) >= int'(len_reg) + 2);
                sb_wdata = '0;
            end
        end

        if (cmd.store_en)
        begin
            if (seen_reg != '0)
                avg_next = acc_reg[BYTE_W-1:0];
            m_we      = 1'b1;
            m_wdata   = {stamp_reg, avg_next};
            fill_next = fill_reg + FW'(1);
            if (int'(wslot_reg) + 1 >= SLOT_COUNT)
                wslot_next = '0;
            else
                wslot_next = wslot_reg + SIW'(1);
            open_next  = 1'b0;
            drop_next  = 1'b0;
            pseen_next = '0;
            seen_next  = '0;
            pos_next   = '0;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        ob_next = ob_reg;
        oi_next = oi_reg;
        ot_next = ot_reg;
        oa_next = oa_reg;
        oe_next = oe_reg;
        oc_next = oc_reg;
        ol_next = ol_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (cmd.load_status)
        begin
            ov_next = 1'b1;
            ob_next = '0;
            oi_next = '0;
            ot_next = '0;
            oa_next = '0;
            oe_next = fill_zero;
            oc_next = COUNT_W'(fill_reg);
            ol_next = 1'b1;
        end
        else if (cmd.rd_load)
        begin
            ov_next = 1'b1;
            ob_next = sb_q;
            oi_next = INDEX_W'(step_reg);
            ot_next = m_q[MW-1:BYTE_W];
            oa_next = m_q[BYTE_W-1:0];
            oe_next = fill_zero;
            oc_next = COUNT_W'(fill_reg);
            ol_next = sts.step_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_hi_reg <= '0;
            sync_lo_reg <= '0;
            wslot_reg   <= '0;
            rslot_reg   <= '0;
            cur_reg     <= '0;
            fill_reg    <= '0;
            avg_reg     <= '0;
            open_reg    <= 1'b0;
            drop_reg    <= 1'b0;
            pseen_reg   <= '0;
            seen_reg    <= '0;
            pos_reg     <= '0;
            step_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            sync_hi_reg <= sync_hi_next;
            sync_lo_reg <= sync_lo_next;
            wslot_reg   <= wslot_next;
            rslot_reg   <= rslot_next;
            cur_reg     <= cur_next;
            fill_reg    <= fill_next;
            avg_reg     <= avg_next;
            open_reg    <= open_next;
            drop_reg    <= drop_next;
            pseen_reg   <= pseen_next;
            seen_reg    <= seen_next;
            pos_reg     <= pos_next;
            step_reg    <= step_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        stamp_reg <= stamp_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        ob_reg    <= ob_next;
        oi_reg    <= oi_next;
        ot_reg    <= ot_next;
        oa_reg    <= oa_next;
        oe_reg    <= oe_next;
        oc_reg    <= oc_next;
        ol_reg    <= ol_next;
    end

    rts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SLOT_COUNT * TELEGRAM_BYTES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (sb_we),
        .waddr (sb_waddr),
        .wdata (sb_wdata),
        .raddr (sb_raddr),
        .rdata (sb_q)
    );

    rts_ram #(
        .WIDTH (MW),
        .DEPTH (SLOT_COUNT)
    ) u_meta_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (wslot_reg),
        .wdata (m_wdata),
        .raddr (cur_reg),
        .rdata (m_q)
    );

    rts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RSSI_WINDOW)
    ) u_rssi_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (eff_pos),
        .wdata (rssi_sample),
        .raddr (step_reg[PW-1:0]),
        .rdata (h_q)
    );

    assign out_valid    = ov_reg;
    assign slot_byte    = ob_reg;
    assign byte_index   = oi_reg;
    assign stored_time  = ot_reg;
    assign rssi_average = oa_reg;
    assign ring_empty   = oe_reg;
    assign stored_count = oc_reg;
    assign last         = ol_reg;

endmodule

// ===== rtl/core/radio_telegram_ring_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_telegram_ring_store
// Ring of received radio telegram slots with timestamp and rssi average.
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) takes one word per func: payload byte,
// rssi sample, commit, read or query. payload and rssi words leave the
// sequencer idle and give no result. a commit sums the rssi window and
// divides the sum by the sample count (both skipped when no sample came),
// then writes sync bytes and zero padding, stores the slot and loads one
// status word into the output register; a telegram begun on a full ring is
// dropped at commit with only the status word. a read of a stored slot gives
// TELEGRAM_BYTES words on the output channel (out_valid/out_ready), each
// fetched from the slot RAM into the output register once it is free; last
// marks the final word. read when empty and query load one status word.
// one item is in work at a time; in_ready stays low until its last word has
// left the output register. a stalled receiver holds the output register and
// the sequencer. reset empties the ring and clears sync bytes and rssi
// history state; no clearing pass is needed. config writes (cfg_we) must go
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module radio_telegram_ring_store #(
    parameter int SLOT_COUNT     = rts_pkg::SLOT_COUNT_DEF,
    parameter int TELEGRAM_BYTES = rts_pkg::TELEGRAM_BYTES_DEF,
    parameter int RSSI_WINDOW    = rts_pkg::RSSI_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rts_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [rts_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rts_pkg::FUNC_W-1:0]    func,
    input  logic [rts_pkg::BYTE_W-1:0]    data_byte,
    input  logic [rts_pkg::BYTE_W-1:0]    rssi_sample,
    input  logic [rts_pkg::TIME_W-1:0]    rx_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rts_pkg::BYTE_W-1:0]    slot_byte,
    output logic [rts_pkg::INDEX_W-1:0]   byte_index,
    output logic [rts_pkg::TIME_W-1:0]    stored_time,
    output logic [rts_pkg::BYTE_W-1:0]    rssi_average,
    output logic                          ring_empty,
    output logic [rts_pkg::COUNT_W-1:0]   stored_count,
    output logic                          last
);
    import rts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    rts_datapath #(
        .SLOT_COUNT     (SLOT_COUNT),
        .TELEGRAM_BYTES (TELEGRAM_BYTES),
        .RSSI_WINDOW    (RSSI_WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .func         (func),
        .data_byte    (data_byte),
        .rssi_sample  (rssi_sample),
        .rx_time      (rx_time),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slot_byte    (slot_byte),
        .byte_index   (byte_index),
        .stored_time  (stored_time),
        .rssi_average (rssi_average),
        .ring_empty   (ring_empty),
        .stored_count (stored_count),
        .last         (last)
    );

endmodule
